### src/mdc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the message id dedup cache
// no dependencies; imported by mdc_home, message_id_dedup_cache and the testbench
package mdc_pkg;

    localparam int HASH_W     = 32;
    localparam int UUID_BYTES = 16;
    localparam int KEY_W      = 64;
    localparam int TIME_W     = 32;
    localparam int KIND_W     = 2;
    localparam int VERDICT_W  = 2;
    localparam int STEP_W     = 5;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHECK  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_SWEEP  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_NEW   = 2'd0,
        VERDICT_DUP   = 2'd1,
        VERDICT_INS   = 2'd2,
        VERDICT_SWEPT = 2'd3
    } t_verdict;

    // one table entry as stored in the slot memory
    typedef struct packed {
        logic              used;
        logic [TIME_W-1:0] seen;
        logic [KEY_W-1:0]  key_high;
        logic [KEY_W-1:0]  key_low;
    } t_entry;

endpackage

### src/mdc_home.sv
`timescale 1ns / 1ps
// home slot unit: byte-serial fnv-1a over the 128-bit id, then a remainder by the
// table depth (low hash bits for a power-of-two depth, else a reciprocal multiply); depends on mdc_pkg
module mdc_home #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [mdc_pkg::KEY_W-1:0]        i_uuid_high,
    input  logic [mdc_pkg::KEY_W-1:0]        i_uuid_low,
    output logic                             o_done,
    output logic [$clog2(TABLE_DEPTH)-1:0]   o_home
);
    import mdc_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam int RSH = HASH_W + AW;
    // floor(2^RSH / depth): the quotient estimate is at most one below the true one
    localparam logic [HASH_W:0] RECIP = (HASH_W+1)'((64'd1 << RSH) / 64'(TABLE_DEPTH));
    localparam logic [HASH_W-1:0] DEPTH_H = HASH_W'(TABLE_DEPTH);
    localparam logic [STEP_W-1:0] LAST_BYTE = STEP_W'(UUID_BYTES - 1);
    localparam logic [STEP_W-1:0] LAST_MOD  = STEP_W'(2);

    typedef enum logic [2:0] {
        H_IDLE = 3'b001,
        H_HASH = 3'b010,
        H_MOD  = 3'b100
    } t_hstate;

    t_hstate                r_state;
    logic [2*KEY_W-1:0]     r_key;
    logic [HASH_W-1:0]      r_hash;
    logic [STEP_W-1:0]      r_step;
    logic [AW-1:0]          r_rem;
    logic                   r_done;
    logic [HASH_W-1:0]      r_quot;
    logic [HASH_W-1:0]      r_part;

    logic [HASH_W-1:0]      w_mix;
    logic [HASH_W-1:0]      w_prod;
    logic [2*HASH_W:0]      w_qprod;
    logic [2*HASH_W:0]      w_qshift;
    logic [HASH_W-1:0]      w_qd;
    logic [HASH_W-1:0]      w_part_fix;

    // hash multiplier: xor in the next byte, multiply by the prime
    assign w_mix  = r_hash ^ {{(HASH_W-8){1'b0}}, r_key[2*KEY_W-1 -: 8]};
    assign w_prod = w_mix * FNV_PRIME;

    // remainder: quotient estimate, partial remainder below twice the depth, one fixup
    assign w_qprod    = {{(HASH_W+1){1'b0}}, r_hash} * {{HASH_W{1'b0}}, RECIP};
    assign w_qshift   = w_qprod >> RSH;
    assign w_qd       = r_quot * DEPTH_H;
    assign w_part_fix = (r_part >= DEPTH_H) ? (r_part - DEPTH_H) : r_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_key   <= {i_uuid_high, i_uuid_low};
                        r_hash  <= FNV_BASIS;
                        r_step  <= '0;
                        r_state <= H_HASH;
                    end
                end
                H_HASH: begin
                    r_hash <= w_prod;
                    r_key  <= {r_key[2*KEY_W-9:0], 8'd0};
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_BYTE) begin
                        r_step <= '0;
                        r_rem  <= '0;
                        if (IS_POW2) begin
                            r_done  <= 1'b1;
                            r_state <= H_IDLE;
                        end else begin
                            r_state <= H_MOD;
                        end
                    end
                end
                H_MOD: begin
                    r_quot <= w_qshift[HASH_W-1:0];
                    r_part <= r_hash - w_qd;
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_MOD) begin
                        r_rem   <= w_part_fix[AW-1:0];
                        r_done  <= 1'b1;
                        r_state <= H_IDLE;
                    end
                end
                default: r_state <= H_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_home = IS_POW2 ? r_hash[AW-1:0] : r_rem;

endmodule

### src/message_id_dedup_cache.sv
`timescale 1ns / 1ps
// seen-message filter: fnv-1a hashed, linearly probed slot table with aging
// depends on mdc_pkg and mdc_home
//
//  channel   signals                                   direction  handshake
//  command   start, busy, i_kind, i_uuid_*, i_now      in         start & !busy
//  result    o_valid, o_verdict                        out        o_valid, 1 cycle
//  config    psel, penable, pwrite, paddr, pwdata,     in/out     apb, pready = 1
//            prdata, pready
//
// check and insert commands run the id through the hash multiplier one byte at a time, then a handoff
// step, plus the remainder steps when TABLE_DEPTH is not a power of two, then a fetch and an exam
// per probed slot (one memory read, one compare); a sweep fetches and examines every slot
// after reset a clearing pass writes every slot of the slot memory
// with busy high; config writes are taken at any time
// results cannot be held off by the receiver
module message_id_dedup_cache #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [mdc_pkg::KIND_W-1:0]        i_kind,
    input  logic [mdc_pkg::KEY_W-1:0]         i_uuid_high,
    input  logic [mdc_pkg::KEY_W-1:0]         i_uuid_low,
    input  logic [mdc_pkg::TIME_W-1:0]        i_now,
    output logic                              o_valid,
    output logic [mdc_pkg::VERDICT_W-1:0]     o_verdict,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import mdc_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);
    localparam logic [TIME_W-1:0] MAX_AGE_RST = 32'd300;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_HASH   = 9'b000000100,
        S_CFETCH = 9'b000001000,
        S_CEXAM  = 9'b000010000,
        S_IFETCH = 9'b000100000,
        S_IEXAM  = 9'b001000000,
        S_SFETCH = 9'b010000000,
        S_SEXAM  = 9'b100000000
    } t_state;

    t_state                 r_state, n_state;
    logic [AW-1:0]          r_idx, n_idx;
    logic [AW-1:0]          r_cnt, n_cnt;
    logic [AW-1:0]          r_home, n_home;
    logic                   r_valid, n_valid;
    t_verdict               r_verdict, n_verdict;
    t_kind                  r_kind;
    logic [KEY_W-1:0]       r_hi;
    logic [KEY_W-1:0]       r_lo;
    logic [TIME_W-1:0]      r_now;
    logic [TIME_W-1:0]      r_max_age;
    t_entry                 r_rd;

    t_entry                 mem [TABLE_DEPTH];

    logic                   w_accept;
    logic                   w_hash_start;
    logic                   w_hash_done;
    logic [AW-1:0]          w_hash_home;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    t_entry                 w_wdata;
    t_entry                 w_new;
    logic                   w_match;
    logic                   w_expired;
    logic                   w_last;
    logic [AW-1:0]          w_idx_inc;
    logic [TIME_W-1:0]      w_age;
    logic                   w_cfg_wr;

    assign w_accept     = start && (r_state == S_IDLE);
    assign w_hash_start = w_accept && (i_kind == KIND_CHECK || i_kind == KIND_INSERT);

    mdc_home #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_home (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_hash_start),
        .i_uuid_high (i_uuid_high),
        .i_uuid_low  (i_uuid_low),
        .o_done      (w_hash_done),
        .o_home      (w_hash_home)
    );

    // slot memory: one write port, one registered read at r_idx
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd <= mem[r_idx];
    end

    assign w_age     = r_now - r_rd.seen;
    assign w_expired = w_age > r_max_age;
    assign w_match   = (r_rd.key_high == r_hi) && (r_rd.key_low == r_lo);
    assign w_last    = (r_cnt == LAST);
    assign w_idx_inc = (r_idx == LAST) ? '0 : r_idx + 1'b1;

    always_comb begin
        w_new.used     = 1'b1;
        w_new.seen     = r_now;
        w_new.key_high = r_hi;
        w_new.key_low  = r_lo;
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_home    = r_home;
        n_valid   = 1'b0;
        n_verdict = r_verdict;
        w_we      = 1'b0;
        w_waddr   = r_idx;
        w_wdata   = w_new;
        unique case (r_state)
            S_CLEAR: begin
                w_we         = 1'b1;
                w_wdata      = '0;
                n_idx        = w_idx_inc;
                if (r_idx == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_idx = '0;
                    n_cnt = '0;
                    case (i_kind) inside
                        KIND_SWEEP:                n_state = S_SFETCH;
                        KIND_CHECK, KIND_INSERT:   n_state = S_HASH;
                        default:                   n_state = S_IDLE;
                    endcase
                end
            end
            S_HASH: begin
                if (w_hash_done) begin
                    n_home  = w_hash_home;
                    n_idx   = w_hash_home;
                    n_cnt   = '0;
                    n_state = (r_kind == KIND_CHECK) ? S_CFETCH : S_IFETCH;
                end
            end
            S_CFETCH: n_state = S_CEXAM;
            S_CEXAM: begin
                if (!r_rd.used || (w_last && !w_match)) begin
                    // no equal key on the chain: fall into insertion
                    n_idx   = r_home;
                    n_cnt   = '0;
                    n_state = S_IFETCH;
                end else if (w_match) begin
                    n_valid   = 1'b1;
                    n_verdict = VERDICT_DUP;
                    n_state   = S_IDLE;
                end else begin
                    n_idx   = w_idx_inc;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_CFETCH;
                end
            end
            S_IFETCH: n_state = S_IEXAM;
            S_IEXAM: begin
                if (!r_rd.used || w_expired || w_last) begin
                    w_we      = 1'b1;
                    // every slot fresh: overwrite the home slot
                    w_waddr   = (!r_rd.used || w_expired) ? r_idx : r_home;
                    n_valid   = 1'b1;
                    n_verdict = (r_kind == KIND_CHECK) ? VERDICT_NEW : VERDICT_INS;
                    n_state   = S_IDLE;
                end else begin
                    n_idx   = w_idx_inc;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_IFETCH;
                end
            end
            S_SFETCH: n_state = S_SEXAM;
            S_SEXAM: begin
                w_wdata      = r_rd;
                w_wdata.used = 1'b0;
                w_we         = r_rd.used && w_expired;
                if (w_last) begin
                    n_valid   = 1'b1;
                    n_verdict = VERDICT_SWEPT;
                    n_state   = S_IDLE;
                end else begin
                    n_idx   = w_idx_inc;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_SFETCH;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_idx     <= '0;
            r_cnt     <= '0;
            r_valid   <= 1'b0;
            r_verdict <= VERDICT_NEW;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_cnt     <= n_cnt;
            r_valid   <= n_valid;
            r_verdict <= n_verdict;
        end
    end

    // transaction payload, captured on accept
    always_ff @(posedge i_clk) begin
        r_home <= n_home;
        if (w_accept) begin
            r_kind <= t_kind'(i_kind);
            r_hi   <= i_uuid_high;
            r_lo   <= i_uuid_low;
            r_now  <= i_now;
        end
    end

    // config register
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= MAX_AGE_RST;
        end else if (w_cfg_wr) begin
            r_max_age <= pwdata;
        end
    end

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == 1'b0) ? r_max_age : '0;
    assign busy      = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_verdict = r_verdict;

endmodule

### bench/tb_message_id_dedup_cache.sv
`timescale 1ns / 1ps
// self-checking testbench for message_id_dedup_cache: commands, apb writes of max_age,
// and an in-bench fnv-1a slot table that predicts every verdict; depends on mdc_pkg and the rtl
module tb_message_id_dedup_cache;
    import mdc_pkg::*;

    localparam int          DEPTH        = 256;
    localparam int          SETTLE       = 2 * DEPTH + 64;  // a full sweep plus margin
    localparam longint      LIMIT        = 4000000;
    localparam logic [2:0]  ADDR_MAX_AGE = 3'd0;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [KIND_W-1:0]     i_kind;
    logic [KEY_W-1:0]      i_uuid_high;
    logic [KEY_W-1:0]      i_uuid_low;
    logic [TIME_W-1:0]     i_now;
    logic                  o_valid;
    logic [VERDICT_W-1:0]  o_verdict;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    message_id_dedup_cache #(.TABLE_DEPTH(DEPTH)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_uuid_high(i_uuid_high), .i_uuid_low(i_uuid_low), .i_now(i_now),
        .o_valid(o_valid), .o_verdict(o_verdict),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow of the slot table and the age register
    bit                 tbl_used   [DEPTH];
    logic [KEY_W-1:0]   tbl_key_hi [DEPTH];
    logic [KEY_W-1:0]   tbl_key_lo [DEPTH];
    logic [TIME_W-1:0]  tbl_seen   [DEPTH];
    logic [31:0]        age_limit;

    t_verdict           verdict_q[$];
    logic [127:0]       key_pool[$];
    logic [TIME_W-1:0]  now_s;
    int                 idle_pct;
    int                 n_err, n_sent, n_silent, n_cfg;
    int                 n_seen [4];
    longint             cycle_cnt;
    t_verdict           exp_v;

    function automatic int unsigned fnv_home(input logic [63:0] hi, input logic [63:0] lo);
        logic [31:0]  h;
        logic [127:0] id;
        h  = FNV_BASIS;
        id = {hi, lo};
        for (int i = 0; i < UUID_BYTES; i++) begin
            h = h ^ {24'd0, id[127 - 8*i -: 8]};
            h = h * FNV_PRIME;
        end
        return h % DEPTH;
    endfunction

    function automatic bit slot_stale(input int unsigned s, input logic [31:0] now);
        logic [31:0] age;
        age = now - tbl_seen[s];
        return age > age_limit;
    endfunction

    function automatic bit holds_key(input int unsigned home, input logic [63:0] hi,
                                     input logic [63:0] lo);
        int unsigned s;
        for (int i = 0; i < DEPTH; i++) begin
            s = (home + i) % DEPTH;
            if (!tbl_used[s]) return 1'b0;
            if (tbl_key_hi[s] == hi && tbl_key_lo[s] == lo) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void place_key(input int unsigned home, input logic [63:0] hi,
                                      input logic [63:0] lo, input logic [31:0] now);
        int unsigned s;
        s = home;
        // first free or expired slot; a table full of fresh entries loses its home slot
        for (int i = 0; i < DEPTH; i++) begin
            if (!tbl_used[(home + i) % DEPTH] || slot_stale((home + i) % DEPTH, now)) begin
                s = (home + i) % DEPTH;
                break;
            end
        end
        tbl_key_hi[s] = hi;
        tbl_key_lo[s] = lo;
        tbl_seen[s]   = now;
        tbl_used[s]   = 1'b1;
    endfunction

    function automatic bit apply_cmd(input t_kind kind, input logic [63:0] hi,
                                     input logic [63:0] lo, input logic [31:0] now,
                                     output t_verdict v);
        int unsigned home;
        v    = VERDICT_NEW;
        home = fnv_home(hi, lo);
        case (kind)
            KIND_SWEEP: begin
                for (int s = 0; s < DEPTH; s++)
                    if (tbl_used[s] && slot_stale(s, now)) tbl_used[s] = 1'b0;
                v = VERDICT_SWEPT;
                return 1'b1;
            end
            KIND_CHECK: begin
                // age is ignored here: an expired key not yet swept is still a duplicate
                if (holds_key(home, hi, lo)) begin
                    v = VERDICT_DUP;
                end else begin
                    place_key(home, hi, lo, now);
                    v = VERDICT_NEW;
                end
                return 1'b1;
            end
            KIND_INSERT: begin
                place_key(home, hi, lo, now);
                v = VERDICT_INS;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: verdict with no transaction pending: expected none, got %0d",
                         $time, o_verdict);
                n_err++;
            end else begin
                exp_v = verdict_q.pop_front();
                if (o_verdict !== exp_v) begin
                    $display("%0t: verdict mismatch: expected %0d, got %0d",
                             $time, exp_v, o_verdict);
                    n_err++;
                end
            end
            if (!$isunknown(o_verdict)) n_seen[o_verdict]++;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("tb_message_id_dedup_cache: errors");
            $finish;
        end
    end

    task automatic send_cmd(input t_kind kind, input logic [63:0] hi, input logic [63:0] lo,
                            input logic [31:0] now);
        bit       offered;
        bit       done;
        t_verdict v;
        done = 1'b0;
        while (!done) begin
            offered      = ($urandom_range(99) >= idle_pct);
            start       <= offered;
            i_kind      <= kind;
            i_uuid_high <= hi;
            i_uuid_low  <= lo;
            i_now       <= now;
            @(posedge i_clk);
            if (offered && !busy) done = 1'b1;
        end
        if (apply_cmd(kind, hi, lo, now, v)) verdict_q.push_back(v);
        else n_silent++;
        n_sent++;
        if (kind != KIND_SWEEP && kind != KIND_NONE) begin
            key_pool.push_back({hi, lo});
            if (key_pool.size() > 64) void'(key_pool.pop_front());
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    // block idle: all verdicts in, any silent command finished
    task automatic settle_block();
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_max_age(input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_AGE;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        age_limit = val;
        n_cfg++;
    endtask

    task automatic key_for_slot(input int unsigned slot, output logic [63:0] hi,
                                output logic [63:0] lo);
        do begin
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
        end while (fnv_home(hi, lo) != slot);
    endtask

    // reset value of max_age, all-zero and all-one keys, time extremes, silent kind
    task automatic test_basic_verdicts();
        idle_pct = 83;
        send_cmd(KIND_CHECK,  '0, '0, 32'd1000);
        send_cmd(KIND_CHECK,  '0, '0, 32'd1000);
        send_cmd(KIND_INSERT, '0, '0, 32'd1000);
        send_cmd(KIND_CHECK,  '1, '1, 32'hFFFF_FFFF);
        send_cmd(KIND_NONE,   '1, '1, 32'hFFFF_FFFF);
        send_cmd(KIND_CHECK,  '1, '1, 32'd0);
    endtask

    // expired but unswept keys, sweep clearing, age wrapping past zero
    task automatic test_aging();
        logic [63:0] hi, lo;
        idle_pct = 20;
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
        send_cmd(KIND_CHECK, hi, lo, 32'd5000);
        send_cmd(KIND_CHECK, hi, lo, 32'd5301);
        send_cmd(KIND_SWEEP, hi, lo, 32'd5301);
        send_cmd(KIND_CHECK, hi, lo, 32'd5301);
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
        send_cmd(KIND_CHECK, hi, lo, 32'hFFFF_FF00);
        send_cmd(KIND_SWEEP, hi, lo, 32'h0000_0010);
        send_cmd(KIND_CHECK, hi, lo, 32'h0000_0010);
    endtask

    // collisions in the last slot wrap to slot 0; zero max_age makes slots reusable
    task automatic test_probing();
        logic [63:0] h1, l1, h2, l2, h3, l3, h4, l4;
        idle_pct = 0;
        settle_block();
        write_max_age(32'd0);
        key_for_slot(DEPTH - 1, h1, l1);
        key_for_slot(DEPTH - 1, h2, l2);
        key_for_slot(DEPTH - 1, h3, l3);
        key_for_slot(0, h4, l4);
        send_cmd(KIND_CHECK, h1, l1, 32'h2000);
        send_cmd(KIND_CHECK, h2, l2, 32'h2000);
        send_cmd(KIND_CHECK, h2, l2, 32'h2000);
        send_cmd(KIND_CHECK, h4, l4, 32'h2000);
        send_cmd(KIND_CHECK, h3, l3, 32'h2001);
        send_cmd(KIND_CHECK, h1, l1, 32'h2001);
    endtask

    // fill every slot with fresh keys, then check and insert into the full table
    task automatic test_full_table();
        logic [63:0]  hi, lo;
        logic [127:0] k;
        idle_pct = 0;
        send_cmd(KIND_SWEEP, '0, '0, 32'h3000);
        settle_block();
        write_max_age(32'hFFFF_FFFF);
        for (int i = 0; i < DEPTH; i++)
            send_cmd(KIND_INSERT, {$urandom, $urandom}, {$urandom, $urandom}, 32'h3000 + i);
        for (int i = 0; i < 4; i++) begin
            send_cmd(KIND_CHECK, {$urandom, $urandom}, {$urandom, $urandom}, 32'h4000);
            k = key_pool[$urandom_range(key_pool.size() - 1)];
            send_cmd(KIND_CHECK, k[127:64], k[63:0], 32'h4000);
        end
        key_for_slot(7, hi, lo);
        send_cmd(KIND_INSERT, hi, lo, 32'h4001);
        send_cmd(KIND_CHECK, hi, lo, 32'h4001);
        settle_block();
        write_max_age(32'd0);
        send_cmd(KIND_SWEEP, '0, '0, 32'h5000);
        now_s = 32'h5000;
    endtask

    task automatic random_cmd(input int step_max);
        t_kind        kind;
        logic [63:0]  hi, lo;
        logic [127:0] k;
        int           r;
        r = $urandom_range(99);
        if (r < 5)       kind = KIND_SWEEP;
        else if (r < 9)  kind = KIND_NONE;
        else if (r < 30) kind = KIND_INSERT;
        else             kind = KIND_CHECK;
        r = $urandom_range(99);
        if (key_pool.size() > 0 && r < 40) begin
            k  = key_pool[$urandom_range(key_pool.size() - 1)];
            hi = k[127:64];
            lo = k[63:0];
        end else if (r < 60) begin
            // crowd a few home slots so that probe chains form and wrap
            case ($urandom_range(2))
                0:       key_for_slot(0, hi, lo);
                1:       key_for_slot(DEPTH - 1, hi, lo);
                default: key_for_slot(DEPTH / 2, hi, lo);
            endcase
        end else begin
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
        end
        if ($urandom_range(99) < 3) now_s = $urandom;
        else now_s = now_s + $urandom_range(step_max);
        send_cmd(kind, hi, lo, now_s);
    endtask

    task automatic test_random_traffic();
        int          pct [4];
        logic [31:0] ages [4];
        int          steps [4];
        pct   = '{0, 83, 0, 20};
        ages  = '{32'd5, 32'd300, 32'h8000_0000, $urandom};
        steps = '{2, 8, 50, 20};
        for (int p = 0; p < 4; p++) begin
            settle_block();
            write_max_age(ages[p]);
            idle_pct = pct[p];
            for (int i = 0; i < 80; i++) begin
                random_cmd(steps[p]);
                if (p == 1 && i == 40) drain_results();
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_kind      <= KIND_NONE;
        i_uuid_high <= '0;
        i_uuid_low  <= '0;
        i_now       <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        age_limit    = 32'd300;
        idle_pct     = 0;
        now_s        = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_verdicts();
        test_aging();
        test_probing();
        test_full_table();
        test_random_traffic();

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
            n_err++;
        end
        $display("covered %0d commands (%0d with no verdict) under %0d max_age settings",
                 n_sent, n_silent, n_cfg);
        $display("verdicts: %0d new, %0d duplicate, %0d insert-only, %0d sweep",
                 n_seen[0], n_seen[1], n_seen[2], n_seen[3]);
        if (n_err == 0)
            $display("tb_message_id_dedup_cache: clean");
        else
            $display("tb_message_id_dedup_cache: errors");
        $finish;
    end

endmodule
